### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the rtl checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// implication after a fixed number of cycles
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("delayed check failed");

`endif

### rtl/mcpl_pkg.sv
// ----------------------------------------------------------------------------
// mcpl_pkg
// types, constants and helpers of the motor current power limiter
// ----------------------------------------------------------------------------
package mcpl_pkg;

   localparam int CurWidth      = 16;
   localparam int MagWidth      = CurWidth + 1;
   localparam int SumWidth      = 18;
   localparam int LimWidth      = 17;
   localparam int VoltWidth     = 16;
   localparam int WordWidth     = 16;
   localparam int WordCalcWidth = WordWidth + 1;
   localparam int OffWidth      = 6;
   localparam int RateWidth     = 8;
   localparam int Lanes         = 4;

   // total limit divider: quotient bits past the overflow check
   localparam int LimQuoBits    = LimWidth;
   localparam int SqWidth       = 2 * VoltWidth;
   localparam int NumWidth      = LimWidth + SqWidth;

   // per-lane scale divider
   localparam int ScaleQuoBits  = CurWidth;
   localparam int ScaleRemWidth = 32;
   localparam int ScaleCmpWidth = SumWidth + ScaleQuoBits;

   localparam int Latency       = 3 + (LimQuoBits + 1) + 1 + (ScaleQuoBits + 1) + 1;

   localparam int AddrWidth     = 5;
   localparam int RegIdxWidth   = AddrWidth - 2;
   localparam int DataWidth     = 32;

   localparam logic [RegIdxWidth-1:0] RegPowerOffset   = 3'd0;
   localparam logic [RegIdxWidth-1:0] RegFallbackWord  = 3'd1;
   localparam logic [RegIdxWidth-1:0] RegCapFull       = 3'd2;
   localparam logic [RegIdxWidth-1:0] RegFloorNormal   = 3'd3;
   localparam logic [RegIdxWidth-1:0] RegFloorBoost    = 3'd4;
   localparam logic [RegIdxWidth-1:0] RegMaxNormal     = 3'd5;
   localparam logic [RegIdxWidth-1:0] RegMaxBoost      = 3'd6;
   localparam logic [RegIdxWidth-1:0] RegFallbackLimit = 3'd7;

   localparam logic [OffWidth-1:0]  RstPowerOffset   = 6'h36;   // -10
   localparam logic [WordWidth-1:0] RstFallbackWord  = 16'd5500;
   localparam logic [VoltWidth-1:0] RstCapFull       = 16'd29000;
   localparam logic [VoltWidth-1:0] RstFloorNormal   = 16'd20000;
   localparam logic [VoltWidth-1:0] RstFloorBoost    = 16'd15000;
   localparam logic [LimWidth-1:0]  RstMaxNormal     = 17'd20000;
   localparam logic [LimWidth-1:0]  RstMaxBoost      = 17'd30000;
   localparam logic [LimWidth-1:0]  RstFallbackLimit = 17'd12000;

   localparam logic [LimWidth-1:0]  LimitMax      = 17'h1FFFF;
   localparam logic [LimWidth-1:0]  LowBufPenalty = 17'd2000;
   localparam logic [RateWidth-1:0] CapLinkMin    = 8'd4;
   localparam logic [RateWidth-1:0] BufThresh     = 8'd10;
   localparam logic [RateWidth-1:0] RefRateFull   = 8'd8;
   localparam logic [RateWidth-1:0] RefRateLow    = 8'd2;
   localparam logic signed [WordCalcWidth-1:0] WattScale = 17'sd100;
   localparam logic [WordCalcWidth-1:0]        BufScale  = 17'd10;

   typedef struct packed {
      logic signed [CurWidth-1:0] current_a;
      logic signed [CurWidth-1:0] current_b;
      logic signed [CurWidth-1:0] current_c;
      logic signed [CurWidth-1:0] current_d;
      logic [VoltWidth-1:0]       cap_voltage_mv;
      logic [7:0]                 power_limit_w;
      logic [7:0]                 energy_buffer_j;
      logic                       boost_key;
      logic [RateWidth-1:0]       cap_link_rate;
      logic [RateWidth-1:0]       referee_link_rate;
   } req_type;

   typedef struct packed {
      logic signed [CurWidth-1:0] limited_a;
      logic signed [CurWidth-1:0] limited_b;
      logic signed [CurWidth-1:0] limited_c;
      logic signed [CurWidth-1:0] limited_d;
      logic [WordWidth-1:0]       power_target_word;
      logic [SumWidth-1:0]        current_sum;
      logic [LimWidth-1:0]        current_limit;
      logic                       was_scaled;
   } rsp_type;

   // per-item data that rides along the pipeline
   typedef struct packed {
      logic [Lanes-1:0][CurWidth-1:0] cur;
      logic [SumWidth-1:0]            sum;
      logic [WordWidth-1:0]           word;
   } carry_type;

   typedef struct packed {
      logic healthy;
      logic buf_low;
   } ctl_type;

   function automatic logic [MagWidth-1:0] abs_mag(input logic [CurWidth-1:0] v);
      abs_mag = v[CurWidth-1] ? (MagWidth'(0) - {1'b1, v}) : {1'b0, v};
   endfunction

endpackage

### rtl/motor_current_power_limiter.sv
// ----------------------------------------------------------------------------
// motor_current_power_limiter
// scales four wheel current commands to a capacitor-voltage based total
// current limit and forms the power target word
// ----------------------------------------------------------------------------
//   channel   ports                                   handshake
//   input     start, busy, req_data                   start & !busy
//   result    rsp_strobe, rsp_data                    one-cycle strobe
//   config    psel, penable, pwrite, paddr, pwdata,   apb write access
//             prdata, pready
//
// one beat enters every cycle; busy is always low
// a result leaves for each input beat, in order
// the depth is set by the 17-step limit divider and the 16-step lane dividers
// synchronous reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_current_power_limiter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mcpl_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output mcpl_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mcpl_pkg::AddrWidth-1:0]      paddr,
   input  logic [mcpl_pkg::DataWidth-1:0]      pwdata,
   output logic [mcpl_pkg::DataWidth-1:0]      prdata,
   output logic                                pready
);

   // configuration registers
   logic [mcpl_pkg::OffWidth-1:0]  cfg_off_ff;
   logic [mcpl_pkg::WordWidth-1:0] cfg_fb_word_ff;
   logic [mcpl_pkg::VoltWidth-1:0] cfg_full_ff;
   logic [mcpl_pkg::VoltWidth-1:0] cfg_floor_n_ff;
   logic [mcpl_pkg::VoltWidth-1:0] cfg_floor_b_ff;
   logic [mcpl_pkg::LimWidth-1:0]  cfg_max_n_ff;
   logic [mcpl_pkg::LimWidth-1:0]  cfg_max_b_ff;
   logic [mcpl_pkg::LimWidth-1:0]  cfg_fb_lim_ff;
   logic                           cfg_wr;
   logic [mcpl_pkg::RegIdxWidth-1:0] cfg_idx;

   // stage 1: magnitudes, voltage differences, power word
   logic                           st1_v_ff;
   mcpl_pkg::carry_type            st1_car_ff, st1_car_in;
   mcpl_pkg::ctl_type              st1_ctl_ff, st1_ctl_in;
   logic [mcpl_pkg::VoltWidth-1:0] st1_d_ff, st1_d_in;
   logic [mcpl_pkg::VoltWidth-1:0] st1_n_ff, st1_n_in;
   logic [mcpl_pkg::LimWidth-1:0]  st1_mx_ff, st1_mx_in;

   // stage 2: squares
   logic                           st2_v_ff;
   mcpl_pkg::carry_type            st2_car_ff;
   mcpl_pkg::ctl_type              st2_ctl_ff;
   logic [mcpl_pkg::SqWidth-1:0]   st2_dd_ff, st2_dd_in;
   logic [mcpl_pkg::SqWidth-1:0]   st2_nn_ff, st2_nn_in;
   logic [mcpl_pkg::LimWidth-1:0]  st2_mx_ff;

   // stage 3: numerator
   logic                           st3_v_ff;
   mcpl_pkg::carry_type            st3_car_ff;
   mcpl_pkg::ctl_type              st3_ctl_ff;
   logic [mcpl_pkg::NumWidth-1:0]  st3_num_ff, st3_num_in;
   logic [mcpl_pkg::SqWidth-1:0]   st3_nn_ff;

   // limit divider, entry 0 holds the overflow check
   logic                           ld_v_ff   [mcpl_pkg::LimQuoBits+1];
   mcpl_pkg::carry_type            ld_car_ff [mcpl_pkg::LimQuoBits+1];
   mcpl_pkg::ctl_type              ld_ctl_ff [mcpl_pkg::LimQuoBits+1];
   logic                           ld_ovf_ff [mcpl_pkg::LimQuoBits+1];
   logic [mcpl_pkg::NumWidth-1:0]  ld_rem_ff [mcpl_pkg::LimQuoBits+1];
   logic [mcpl_pkg::NumWidth-1:0]  ld_rem_in [mcpl_pkg::LimQuoBits+1];
   logic [mcpl_pkg::SqWidth-1:0]   ld_nn_ff  [mcpl_pkg::LimQuoBits+1];
   logic [mcpl_pkg::LimWidth-1:0]  ld_q_ff   [mcpl_pkg::LimQuoBits+1];
   logic [mcpl_pkg::LimWidth-1:0]  ld_q_in   [mcpl_pkg::LimQuoBits+1];
   logic                           ld_ovf_in;

   // final limit
   logic                           lim_v_ff;
   mcpl_pkg::carry_type            lim_car_ff;
   logic [mcpl_pkg::LimWidth-1:0]  lim_ff, lim_in;
   logic [mcpl_pkg::LimWidth-1:0]  lim_raw;

   // lane dividers, entry 0 holds the products
   logic                           sc_v_ff   [mcpl_pkg::ScaleQuoBits+1];
   mcpl_pkg::carry_type            sc_car_ff [mcpl_pkg::ScaleQuoBits+1];
   logic [mcpl_pkg::LimWidth-1:0]  sc_lim_ff [mcpl_pkg::ScaleQuoBits+1];
   logic                           sc_scl_ff [mcpl_pkg::ScaleQuoBits+1];
   logic [mcpl_pkg::ScaleRemWidth-1:0] sc_rem_ff [mcpl_pkg::ScaleQuoBits+1][mcpl_pkg::Lanes];
   logic [mcpl_pkg::ScaleRemWidth-1:0] sc_rem_in [mcpl_pkg::ScaleQuoBits+1][mcpl_pkg::Lanes];
   logic [mcpl_pkg::ScaleQuoBits-1:0]  sc_q_ff   [mcpl_pkg::ScaleQuoBits+1][mcpl_pkg::Lanes];
   logic [mcpl_pkg::ScaleQuoBits-1:0]  sc_q_in   [mcpl_pkg::ScaleQuoBits+1][mcpl_pkg::Lanes];
   logic [2*mcpl_pkg::LimWidth-1:0]    sc_prod   [mcpl_pkg::Lanes];
   logic                               sc_scl_in;

   // output register
   logic                           rsp_strobe_ff;
   mcpl_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // ---------------------------------------------------------------- config
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign cfg_idx = paddr[mcpl_pkg::AddrWidth-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_off_ff     <= mcpl_pkg::RstPowerOffset;
         cfg_fb_word_ff <= mcpl_pkg::RstFallbackWord;
         cfg_full_ff    <= mcpl_pkg::RstCapFull;
         cfg_floor_n_ff <= mcpl_pkg::RstFloorNormal;
         cfg_floor_b_ff <= mcpl_pkg::RstFloorBoost;
         cfg_max_n_ff   <= mcpl_pkg::RstMaxNormal;
         cfg_max_b_ff   <= mcpl_pkg::RstMaxBoost;
         cfg_fb_lim_ff  <= mcpl_pkg::RstFallbackLimit;
      end else if (cfg_wr) begin
         case (cfg_idx)
            mcpl_pkg::RegPowerOffset:   cfg_off_ff     <= pwdata[mcpl_pkg::OffWidth-1:0];
            mcpl_pkg::RegFallbackWord:  cfg_fb_word_ff <= pwdata[mcpl_pkg::WordWidth-1:0];
            mcpl_pkg::RegCapFull:       cfg_full_ff    <= pwdata[mcpl_pkg::VoltWidth-1:0];
            mcpl_pkg::RegFloorNormal:   cfg_floor_n_ff <= pwdata[mcpl_pkg::VoltWidth-1:0];
            mcpl_pkg::RegFloorBoost:    cfg_floor_b_ff <= pwdata[mcpl_pkg::VoltWidth-1:0];
            mcpl_pkg::RegMaxNormal:     cfg_max_n_ff   <= pwdata[mcpl_pkg::LimWidth-1:0];
            mcpl_pkg::RegMaxBoost:      cfg_max_b_ff   <= pwdata[mcpl_pkg::LimWidth-1:0];
            mcpl_pkg::RegFallbackLimit: cfg_fb_lim_ff  <= pwdata[mcpl_pkg::LimWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         mcpl_pkg::RegPowerOffset:   prdata = mcpl_pkg::DataWidth'(cfg_off_ff);
         mcpl_pkg::RegFallbackWord:  prdata = mcpl_pkg::DataWidth'(cfg_fb_word_ff);
         mcpl_pkg::RegCapFull:       prdata = mcpl_pkg::DataWidth'(cfg_full_ff);
         mcpl_pkg::RegFloorNormal:   prdata = mcpl_pkg::DataWidth'(cfg_floor_n_ff);
         mcpl_pkg::RegFloorBoost:    prdata = mcpl_pkg::DataWidth'(cfg_floor_b_ff);
         mcpl_pkg::RegMaxNormal:     prdata = mcpl_pkg::DataWidth'(cfg_max_n_ff);
         mcpl_pkg::RegMaxBoost:      prdata = mcpl_pkg::DataWidth'(cfg_max_b_ff);
         mcpl_pkg::RegFallbackLimit: prdata = mcpl_pkg::DataWidth'(cfg_fb_lim_ff);
         default:                    prdata = '0;
      endcase
   end

   // --------------------------------------------------------------- stage 1
   always_comb begin
      logic [mcpl_pkg::VoltWidth-1:0]               flr;
      logic signed [9:0]                            psum;
      logic signed [mcpl_pkg::WordCalcWidth-1:0]    wbase;
      logic signed [mcpl_pkg::WordCalcWidth-1:0]    wsum;
      logic [mcpl_pkg::WordCalcWidth-1:0]           bonus;
      logic [mcpl_pkg::MagWidth-1:0]                mag [mcpl_pkg::Lanes];

      st1_car_in.cur = {req_data.current_d, req_data.current_c,
                        req_data.current_b, req_data.current_a};
      for (int j = 0; j < mcpl_pkg::Lanes; j++) begin
         mag[j] = mcpl_pkg::abs_mag(st1_car_in.cur[j]);
      end
      st1_car_in.sum = mcpl_pkg::SumWidth'(mag[0]) + mcpl_pkg::SumWidth'(mag[1])
                     + mcpl_pkg::SumWidth'(mag[2]) + mcpl_pkg::SumWidth'(mag[3]);

      flr       = req_data.boost_key ? cfg_floor_b_ff : cfg_floor_n_ff;
      st1_mx_in = req_data.boost_key ? cfg_max_b_ff : cfg_max_n_ff;
      st1_d_in  = (req_data.cap_voltage_mv >= flr) ? (req_data.cap_voltage_mv - flr)
                                                   : (flr - req_data.cap_voltage_mv);
      st1_n_in  = (cfg_full_ff >= flr) ? (cfg_full_ff - flr) : (flr - cfg_full_ff);

      st1_ctl_in.healthy = req_data.cap_link_rate >= mcpl_pkg::CapLinkMin;
      st1_ctl_in.buf_low = req_data.energy_buffer_j < mcpl_pkg::BufThresh;

      psum  = $signed({2'b00, req_data.power_limit_w})
            + $signed({{4{cfg_off_ff[mcpl_pkg::OffWidth-1]}}, cfg_off_ff});
      wbase = $signed({{7{psum[9]}}, psum}) * mcpl_pkg::WattScale;
      bonus = mcpl_pkg::WordCalcWidth'(req_data.energy_buffer_j) * mcpl_pkg::BufScale;
      if (req_data.referee_link_rate > mcpl_pkg::RefRateFull) begin
         wsum = (req_data.energy_buffer_j > mcpl_pkg::BufThresh) ? (wbase + $signed(bonus))
                                                                 : wbase;
      end else if (req_data.referee_link_rate > mcpl_pkg::RefRateLow) begin
         wsum = wbase;
      end else begin
         wsum = $signed({1'b0, cfg_fb_word_ff});
      end
      st1_car_in.word = wsum[mcpl_pkg::WordCalcWidth-1] ? '0 : wsum[mcpl_pkg::WordWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_v_ff <= 1'b0;
      end else begin
         st1_v_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      st1_car_ff <= st1_car_in;
      st1_ctl_ff <= st1_ctl_in;
      st1_d_ff   <= st1_d_in;
      st1_n_ff   <= st1_n_in;
      st1_mx_ff  <= st1_mx_in;
   end

   // ------------------------------------------------------- stages 2 and 3
   assign st2_dd_in  = mcpl_pkg::SqWidth'(st1_d_ff) * mcpl_pkg::SqWidth'(st1_d_ff);
   assign st2_nn_in  = mcpl_pkg::SqWidth'(st1_n_ff) * mcpl_pkg::SqWidth'(st1_n_ff);
   assign st3_num_in = mcpl_pkg::NumWidth'(st2_mx_ff) * mcpl_pkg::NumWidth'(st2_dd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_v_ff <= 1'b0;
         st3_v_ff <= 1'b0;
      end else begin
         st2_v_ff <= st1_v_ff;
         st3_v_ff <= st2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      st2_car_ff <= st1_car_ff;
      st2_ctl_ff <= st1_ctl_ff;
      st2_dd_ff  <= st2_dd_in;
      st2_nn_ff  <= st2_nn_in;
      st2_mx_ff  <= st1_mx_ff;
      st3_car_ff <= st2_car_ff;
      st3_ctl_ff <= st2_ctl_ff;
      st3_num_ff <= st3_num_in;
      st3_nn_ff  <= st2_nn_ff;
   end

   // ------------------------------------------------------- limit divider
   // quotient at or above 2^17 saturates; a zero denominator lands here too
   assign ld_ovf_in = st3_num_ff >= {st3_nn_ff, {mcpl_pkg::LimQuoBits{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_v_ff[0] <= 1'b0;
      end else begin
         ld_v_ff[0] <= st3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      ld_car_ff[0] <= st3_car_ff;
      ld_ctl_ff[0] <= st3_ctl_ff;
      ld_ovf_ff[0] <= ld_ovf_in;
      ld_rem_ff[0] <= st3_num_ff;
      ld_nn_ff[0]  <= st3_nn_ff;
      ld_q_ff[0]   <= '0;
   end

   for (genvar k = 0; k < mcpl_pkg::LimQuoBits; k++) begin : g_ld
      localparam int Sh = mcpl_pkg::LimQuoBits - 1 - k;
      logic [mcpl_pkg::NumWidth-1:0] dv;
      logic                          ge;

      always_comb begin
         dv            = mcpl_pkg::NumWidth'(ld_nn_ff[k]) << Sh;
         ge            = ld_rem_ff[k] >= dv;
         ld_rem_in[k]  = ge ? (ld_rem_ff[k] - dv) : ld_rem_ff[k];
         ld_q_in[k]    = ld_q_ff[k];
         ld_q_in[k][Sh] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ld_v_ff[k+1] <= 1'b0;
         end else begin
            ld_v_ff[k+1] <= ld_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         ld_car_ff[k+1] <= ld_car_ff[k];
         ld_ctl_ff[k+1] <= ld_ctl_ff[k];
         ld_ovf_ff[k+1] <= ld_ovf_ff[k];
         ld_rem_ff[k+1] <= ld_rem_in[k];
         ld_nn_ff[k+1]  <= ld_nn_ff[k];
         ld_q_ff[k+1]   <= ld_q_in[k];
      end
   end

   assign ld_rem_in[mcpl_pkg::LimQuoBits] = ld_rem_ff[mcpl_pkg::LimQuoBits];
   assign ld_q_in[mcpl_pkg::LimQuoBits]   = ld_q_ff[mcpl_pkg::LimQuoBits];

   // ---------------------------------------------------------- final limit
   always_comb begin
      if (ld_ctl_ff[mcpl_pkg::LimQuoBits].healthy) begin
         lim_raw = ld_ovf_ff[mcpl_pkg::LimQuoBits] ? mcpl_pkg::LimitMax
                                                   : ld_q_in[mcpl_pkg::LimQuoBits];
      end else begin
         lim_raw = cfg_fb_lim_ff;
      end
      if (ld_ctl_ff[mcpl_pkg::LimQuoBits].buf_low) begin
         lim_in = (lim_raw >= mcpl_pkg::LowBufPenalty) ? (lim_raw - mcpl_pkg::LowBufPenalty)
                                                       : '0;
      end else begin
         lim_in = lim_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_v_ff <= 1'b0;
      end else begin
         lim_v_ff <= ld_v_ff[mcpl_pkg::LimQuoBits];
      end
   end

   always_ff @(posedge clock) begin
      lim_car_ff <= ld_car_ff[mcpl_pkg::LimQuoBits];
      lim_ff     <= lim_in;
   end

   // ------------------------------------------------------ lane products
   always_comb begin
      sc_scl_in = lim_car_ff.sum > mcpl_pkg::SumWidth'(lim_ff);
      for (int j = 0; j < mcpl_pkg::Lanes; j++) begin
         sc_prod[j] = (2*mcpl_pkg::LimWidth)'(mcpl_pkg::abs_mag(lim_car_ff.cur[j]))
                    * (2*mcpl_pkg::LimWidth)'(lim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_v_ff[0] <= 1'b0;
      end else begin
         sc_v_ff[0] <= lim_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      sc_car_ff[0] <= lim_car_ff;
      sc_lim_ff[0] <= lim_ff;
      sc_scl_ff[0] <= sc_scl_in;
      for (int j = 0; j < mcpl_pkg::Lanes; j++) begin
         sc_rem_ff[0][j] <= sc_prod[j][mcpl_pkg::ScaleRemWidth-1:0];
         sc_q_ff[0][j]   <= '0;
      end
   end

   // ------------------------------------------------------- lane dividers
   for (genvar k = 0; k < mcpl_pkg::ScaleQuoBits; k++) begin : g_sc
      localparam int Sh = mcpl_pkg::ScaleQuoBits - 1 - k;
      logic [mcpl_pkg::ScaleCmpWidth-1:0] dv;
      logic [mcpl_pkg::Lanes-1:0]         ge;

      always_comb begin
         dv = mcpl_pkg::ScaleCmpWidth'(sc_car_ff[k].sum) << Sh;
         for (int j = 0; j < mcpl_pkg::Lanes; j++) begin
            ge[j] = mcpl_pkg::ScaleCmpWidth'(sc_rem_ff[k][j]) >= dv;
            sc_rem_in[k][j] = ge[j] ? (sc_rem_ff[k][j] - dv[mcpl_pkg::ScaleRemWidth-1:0])
                                    : sc_rem_ff[k][j];
            sc_q_in[k][j]     = sc_q_ff[k][j];
            sc_q_in[k][j][Sh] = ge[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sc_v_ff[k+1] <= 1'b0;
         end else begin
            sc_v_ff[k+1] <= sc_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         sc_car_ff[k+1] <= sc_car_ff[k];
         sc_lim_ff[k+1] <= sc_lim_ff[k];
         sc_scl_ff[k+1] <= sc_scl_ff[k];
         for (int j = 0; j < mcpl_pkg::Lanes; j++) begin
            sc_rem_ff[k+1][j] <= sc_rem_in[k][j];
            sc_q_ff[k+1][j]   <= sc_q_in[k][j];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < mcpl_pkg::Lanes; j++) begin
         sc_rem_in[mcpl_pkg::ScaleQuoBits][j] = sc_rem_ff[mcpl_pkg::ScaleQuoBits][j];
         sc_q_in[mcpl_pkg::ScaleQuoBits][j]   = sc_q_ff[mcpl_pkg::ScaleQuoBits][j];
      end
   end

   // -------------------------------------------------------------- output
   always_comb begin
      logic [mcpl_pkg::Lanes-1:0][mcpl_pkg::CurWidth-1:0] lim_cur;
      mcpl_pkg::carry_type car;

      car = sc_car_ff[mcpl_pkg::ScaleQuoBits];
      for (int j = 0; j < mcpl_pkg::Lanes; j++) begin
         if (sc_scl_ff[mcpl_pkg::ScaleQuoBits]) begin
            lim_cur[j] = car.cur[j][mcpl_pkg::CurWidth-1]
                       ? (mcpl_pkg::CurWidth'(0) - sc_q_in[mcpl_pkg::ScaleQuoBits][j])
                       : sc_q_in[mcpl_pkg::ScaleQuoBits][j];
         end else begin
            lim_cur[j] = car.cur[j];
         end
      end
      rsp_data_in.limited_a         = lim_cur[0];
      rsp_data_in.limited_b         = lim_cur[1];
      rsp_data_in.limited_c         = lim_cur[2];
      rsp_data_in.limited_d         = lim_cur[3];
      rsp_data_in.power_target_word = car.word;
      rsp_data_in.current_sum       = car.sum;
      rsp_data_in.current_limit     = sc_lim_ff[mcpl_pkg::ScaleQuoBits];
      rsp_data_in.was_scaled        = sc_scl_ff[mcpl_pkg::ScaleQuoBits];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sc_v_ff[mcpl_pkg::ScaleQuoBits];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------- assertions
   `ASSERT_DELAY(a_beat_latency, clock, reset, start && !busy, mcpl_pkg::Latency, rsp_strobe)
   `ASSERT_IMPLIES(a_scaled_over, clock, reset, rsp_strobe && rsp_data.was_scaled, rsp_data.current_sum > mcpl_pkg::SumWidth'(rsp_data.current_limit))
   `ASSERT_IMPLIES(a_unscaled_pass, clock, reset, rsp_strobe && !rsp_data.was_scaled, rsp_data.current_sum <= mcpl_pkg::SumWidth'(rsp_data.current_limit))

endmodule

### dv/mcpl_result_checker.sv
// ----------------------------------------------------------------------------
// mcpl_result_checker
// watches the command, result and register ports of the current limiter,
// keeps its own copy of the limit registers, works out the limited currents,
// limit, sum and power word of every accepted command beat, and compares
// each result beat field by field with the oldest outstanding prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcpl_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  mcpl_pkg::req_type              req_data,
   input  logic                           rsp_strobe,
   input  mcpl_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mcpl_pkg::AddrWidth-1:0] paddr,
   input  logic [mcpl_pkg::DataWidth-1:0] pwdata,
   input  logic                           pready,
   output int                             errors,
   output int                             pending
);

   logic signed [mcpl_pkg::OffWidth-1:0] power_offset;
   logic [mcpl_pkg::WordWidth-1:0]       fallback_word;
   logic [mcpl_pkg::VoltWidth-1:0]       cap_full;
   logic [mcpl_pkg::VoltWidth-1:0]       floor_normal;
   logic [mcpl_pkg::VoltWidth-1:0]       floor_boost;
   logic [mcpl_pkg::LimWidth-1:0]        max_normal;
   logic [mcpl_pkg::LimWidth-1:0]        max_boost;
   logic [mcpl_pkg::LimWidth-1:0]        fallback_limit;

   mcpl_pkg::rsp_type limited_beats_due [$];

   function automatic mcpl_pkg::rsp_type limit_currents(input mcpl_pkg::req_type r);
      int                            cur [mcpl_pkg::Lanes];
      longint unsigned               mag [mcpl_pkg::Lanes];
      logic [mcpl_pkg::CurWidth-1:0] lane_out [mcpl_pkg::Lanes];
      longint unsigned               total, flr, ceiling, d, n, q, lim;
      longint                        raw, word;
      logic                          scaled;
      mcpl_pkg::rsp_type             o;
      cur[0] = int'(r.current_a);
      cur[1] = int'(r.current_b);
      cur[2] = int'(r.current_c);
      cur[3] = int'(r.current_d);
      total = 0;
      for (int i = 0; i < mcpl_pkg::Lanes; i++) begin
         mag[i] = (cur[i] < 0) ? longint'(-cur[i]) : longint'(cur[i]);
         total += mag[i];
      end

      if (r.cap_link_rate >= mcpl_pkg::CapLinkMin) begin
         flr     = r.boost_key ? floor_boost : floor_normal;
         ceiling = r.boost_key ? max_boost : max_normal;
         d = (r.cap_voltage_mv >= flr) ? r.cap_voltage_mv - flr : flr - r.cap_voltage_mv;
         n = (cap_full >= flr) ? cap_full - flr : flr - cap_full;
         if (n == 0) begin
            raw = longint'(mcpl_pkg::LimitMax);
         end else begin
            q = (ceiling * d * d) / (n * n);
            raw = (q > mcpl_pkg::LimitMax) ? longint'(mcpl_pkg::LimitMax) : longint'(q);
         end
      end else begin
         raw = longint'(fallback_limit);
      end
      if (r.energy_buffer_j < mcpl_pkg::BufThresh) raw = raw - longint'(mcpl_pkg::LowBufPenalty);
      if (raw < 0) raw = 0;
      if (raw > longint'(mcpl_pkg::LimitMax)) raw = longint'(mcpl_pkg::LimitMax);
      lim = raw;

      if (r.referee_link_rate > mcpl_pkg::RefRateFull) begin
         word = (longint'(r.power_limit_w) + longint'(power_offset)) * 100;
         if (r.energy_buffer_j > mcpl_pkg::BufThresh) word += longint'(r.energy_buffer_j) * 10;
      end else if (r.referee_link_rate > mcpl_pkg::RefRateLow) begin
         word = (longint'(r.power_limit_w) + longint'(power_offset)) * 100;
      end else begin
         word = longint'(fallback_word);
      end
      if (word < 0) word = 0;
      if (word > 65535) word = 65535;

      scaled = total > lim;
      for (int i = 0; i < mcpl_pkg::Lanes; i++) begin
         if (scaled) begin
            q = (mag[i] * lim) / total;
            lane_out[i] = (cur[i] < 0) ? mcpl_pkg::CurWidth'(-longint'(q))
                                       : mcpl_pkg::CurWidth'(q);
         end else begin
            lane_out[i] = mcpl_pkg::CurWidth'(cur[i]);
         end
      end
      o.limited_a         = lane_out[0];
      o.limited_b         = lane_out[1];
      o.limited_c         = lane_out[2];
      o.limited_d         = lane_out[3];
      o.power_target_word = mcpl_pkg::WordWidth'(word);
      o.current_sum       = mcpl_pkg::SumWidth'(total);
      o.current_limit     = mcpl_pkg::LimWidth'(lim);
      o.was_scaled        = scaled;
      return o;
   endfunction

   function automatic int field_diff(input string name,
                                     input logic [mcpl_pkg::SumWidth-1:0] want_v,
                                     input logic [mcpl_pkg::SumWidth-1:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      int                bad;
      mcpl_pkg::rsp_type want;
      bad = 0;
      if (reset) begin
         power_offset   <= mcpl_pkg::RstPowerOffset;
         fallback_word  <= mcpl_pkg::RstFallbackWord;
         cap_full       <= mcpl_pkg::RstCapFull;
         floor_normal   <= mcpl_pkg::RstFloorNormal;
         floor_boost    <= mcpl_pkg::RstFloorBoost;
         max_normal     <= mcpl_pkg::RstMaxNormal;
         max_boost      <= mcpl_pkg::RstMaxBoost;
         fallback_limit <= mcpl_pkg::RstFallbackLimit;
         limited_beats_due.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[mcpl_pkg::AddrWidth-1:2])
               mcpl_pkg::RegPowerOffset:   power_offset   <= pwdata[mcpl_pkg::OffWidth-1:0];
               mcpl_pkg::RegFallbackWord:  fallback_word  <= pwdata[mcpl_pkg::WordWidth-1:0];
               mcpl_pkg::RegCapFull:       cap_full       <= pwdata[mcpl_pkg::VoltWidth-1:0];
               mcpl_pkg::RegFloorNormal:   floor_normal   <= pwdata[mcpl_pkg::VoltWidth-1:0];
               mcpl_pkg::RegFloorBoost:    floor_boost    <= pwdata[mcpl_pkg::VoltWidth-1:0];
               mcpl_pkg::RegMaxNormal:     max_normal     <= pwdata[mcpl_pkg::LimWidth-1:0];
               mcpl_pkg::RegMaxBoost:      max_boost      <= pwdata[mcpl_pkg::LimWidth-1:0];
               mcpl_pkg::RegFallbackLimit: fallback_limit <= pwdata[mcpl_pkg::LimWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (limited_beats_due.size() == 0) begin
               $display("%0t: result beat with nothing outstanding, expected none actual %0h",
                        $time, rsp_data);
               bad++;
            end else begin
               want = limited_beats_due.pop_front();
               bad += field_diff("limited_a", want.limited_a, rsp_data.limited_a);
               bad += field_diff("limited_b", want.limited_b, rsp_data.limited_b);
               bad += field_diff("limited_c", want.limited_c, rsp_data.limited_c);
               bad += field_diff("limited_d", want.limited_d, rsp_data.limited_d);
               bad += field_diff("power_target_word", want.power_target_word,
                                 rsp_data.power_target_word);
               bad += field_diff("current_sum", want.current_sum, rsp_data.current_sum);
               bad += field_diff("current_limit", want.current_limit, rsp_data.current_limit);
               bad += field_diff("was_scaled", want.was_scaled, rsp_data.was_scaled);
            end
         end
         if (start && !busy) limited_beats_due.push_back(limit_currents(req_data));
         errors  <= errors + bad;
         pending <= limited_beats_due.size();
      end
   end

endmodule

### dv/motor_current_power_limiter_tb.sv
// ----------------------------------------------------------------------------
// motor_current_power_limiter_tb
// drives the current limiter with directed corner frames and bursts of
// random frames under several register settings, including zero and
// inverted voltage spans; the result checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_current_power_limiter_tb;

   localparam int StallLimit    = 400;
   localparam int BeatsPerPhase = 210;

   typedef enum int {
      SetTypical,
      SetMinimum,
      SetMaximum,
      SetFloorAbove,
      SetNarrowSpan
   } setting_kind_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   mcpl_pkg::req_type              req_data;
   logic                           rsp_strobe;
   mcpl_pkg::rsp_type              rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [mcpl_pkg::AddrWidth-1:0] paddr;
   logic [mcpl_pkg::DataWidth-1:0] pwdata;
   logic [mcpl_pkg::DataWidth-1:0] prdata;
   logic                           pready;
   int                             errors;
   int                             pending;
   int                             idle_cycles;
   logic [mcpl_pkg::DataWidth-1:0] reg_shadow [8];
   setting_kind_type               phase_plan [7] = '{SetTypical, SetMinimum, SetMaximum,
                                                      SetFloorAbove, SetNarrowSpan,
                                                      SetTypical, SetTypical};

   motor_current_power_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   mcpl_result_checker limit_watch (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
         $display("motor_current_power_limiter_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic mcpl_pkg::req_type frame(input int a, input int b, input int c,
                                               input int d, input int volt, input int watts,
                                               input int energy, input int boost,
                                               input int cap_rate, input int ref_rate);
      mcpl_pkg::req_type f;
      f.current_a         = mcpl_pkg::CurWidth'(a);
      f.current_b         = mcpl_pkg::CurWidth'(b);
      f.current_c         = mcpl_pkg::CurWidth'(c);
      f.current_d         = mcpl_pkg::CurWidth'(d);
      f.cap_voltage_mv    = mcpl_pkg::VoltWidth'(volt);
      f.power_limit_w     = 8'(watts);
      f.energy_buffer_j   = 8'(energy);
      f.boost_key         = 1'(boost);
      f.cap_link_rate     = mcpl_pkg::RateWidth'(cap_rate);
      f.referee_link_rate = mcpl_pkg::RateWidth'(ref_rate);
      return f;
   endfunction

   function automatic logic [mcpl_pkg::CurWidth-1:0] random_current();
      case ($urandom_range(0, 3))
         0: return mcpl_pkg::CurWidth'($urandom);
         1: return mcpl_pkg::CurWidth'(int'($urandom_range(0, 4000)) - 2000);
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
         default: return mcpl_pkg::CurWidth'(int'($urandom_range(0, 16000)) - 8000);
      endcase
   endfunction

   function automatic mcpl_pkg::req_type random_frame();
      mcpl_pkg::req_type f;
      int                base;
      f.current_a = random_current();
      f.current_b = random_current();
      f.current_c = random_current();
      f.current_d = random_current();
      f.boost_key = 1'($urandom);
      case ($urandom_range(0, 3))
         0: base = int'($urandom_range(0, 65535));
         1: base = int'(reg_shadow[mcpl_pkg::RegCapFull][mcpl_pkg::VoltWidth-1:0]);
         2: base = f.boost_key
                 ? int'(reg_shadow[mcpl_pkg::RegFloorBoost][mcpl_pkg::VoltWidth-1:0])
                 : int'(reg_shadow[mcpl_pkg::RegFloorNormal][mcpl_pkg::VoltWidth-1:0]);
         default: base = $urandom_range(0, 1) ? 65535 : 0;
      endcase
      f.cap_voltage_mv    = mcpl_pkg::VoltWidth'(base + int'($urandom_range(0, 600)) - 300);
      f.power_limit_w     = 8'($urandom);
      f.energy_buffer_j   = $urandom_range(0, 2) == 0 ? 8'($urandom_range(5, 15)) : 8'($urandom);
      f.cap_link_rate     = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
      f.referee_link_rate = $urandom_range(0, 1) ? 8'($urandom_range(0, 12)) : 8'($urandom);
      return f;
   endfunction

   task automatic send_frame(input mcpl_pkg::req_type f);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start    <= 1'b0;
      req_data <= random_frame();
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      hold_off(1);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mcpl_pkg::RegIdxWidth-1:0] idx,
                            input logic [mcpl_pkg::DataWidth-1:0] value);
      reg_shadow[idx] = value;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_settings(input setting_kind_type kind);
      logic [mcpl_pkg::DataWidth-1:0] vals [8];
      vals[mcpl_pkg::RegPowerOffset]   = mcpl_pkg::DataWidth'(int'($urandom_range(0, 40)) - 20);
      vals[mcpl_pkg::RegFallbackWord]  = $urandom_range(0, 65535);
      vals[mcpl_pkg::RegCapFull]       = $urandom_range(1000, 60000);
      vals[mcpl_pkg::RegFloorNormal]   = $urandom_range(0, 60000);
      vals[mcpl_pkg::RegFloorBoost]    = $urandom_range(0, 60000);
      vals[mcpl_pkg::RegMaxNormal]     = $urandom_range(0, 131071);
      vals[mcpl_pkg::RegMaxBoost]      = $urandom_range(0, 131071);
      vals[mcpl_pkg::RegFallbackLimit] = $urandom_range(0, 131071);
      case (kind)
         SetMinimum: begin
            foreach (vals[i]) vals[i] = '0;
            vals[mcpl_pkg::RegPowerOffset] = 32'h20;
         end
         SetMaximum: begin
            foreach (vals[i]) vals[i] = '1;
            vals[mcpl_pkg::RegPowerOffset] = 32'd31;
            vals[mcpl_pkg::RegFloorNormal] = 32'd0;
         end
         SetFloorAbove: begin
            vals[mcpl_pkg::RegCapFull]     = 32'd1000;
            vals[mcpl_pkg::RegFloorNormal] = 32'd60000;
            vals[mcpl_pkg::RegFloorBoost]  = 32'd30000;
         end
         SetNarrowSpan: begin
            vals[mcpl_pkg::RegCapFull]     = 32'd30000;
            vals[mcpl_pkg::RegFloorNormal] = 32'd29999;
            vals[mcpl_pkg::RegFloorBoost]  = 32'd30001;
         end
         default: ;
      endcase
      for (int i = 0; i < 8; i++) csr_write(mcpl_pkg::RegIdxWidth'(i), vals[i]);
   endtask

   task automatic send_bursts(input int beats);
      int burst;
      while (beats > 0) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         for (int i = 0; i < burst && beats > 0; i++) begin
            send_frame(random_frame());
            beats--;
         end
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 15));
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      reg_shadow[mcpl_pkg::RegCapFull]     = mcpl_pkg::RstCapFull;
      reg_shadow[mcpl_pkg::RegFloorNormal] = mcpl_pkg::RstFloorNormal;
      reg_shadow[mcpl_pkg::RegFloorBoost]  = mcpl_pkg::RstFloorBoost;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: fallback, saturation, floor, full, buffer and rate thresholds
      send_frame(frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_frame(frame(-32768, -32768, -32768, -32768, 65535, 255, 255, 1, 255, 255));
      send_frame(frame(32767, 32767, 32767, 32767, 29000, 100, 10, 0, 4, 9));
      send_frame(frame(1000, -1000, 500, -500, 20000, 0, 9, 0, 4, 8));
      send_frame(frame(0, 0, 0, 0, 20000, 0, 9, 0, 4, 8));
      send_frame(frame(12000, -12000, 12000, -12000, 0, 50, 11, 0, 3, 9));
      send_frame(frame(100, 200, -300, 400, 15000, 80, 200, 1, 4, 3));
      send_frame(frame(5000, -7000, 9000, -11000, 10000, 10, 12, 0, 4, 2));
      send_frame(frame(32767, -32768, 1, -1, 24500, 120, 10, 1, 200, 200));
      send_frame(frame(7, -7, 3, -3, 29000, 255, 9, 1, 4, 255));
      send_frame(frame(-20000, 20000, -1, 1, 33000, 9, 11, 1, 5, 9));
      send_frame(frame(4000, 4000, 4000, 4000, 0, 255, 0, 1, 3, 1));
      hold_off(3);

      // floor equal to full, boost floor above full
      drain();
      csr_write(mcpl_pkg::RegCapFull, 32'd20000);
      csr_write(mcpl_pkg::RegFloorBoost, 32'd40000);
      send_frame(frame(30000, -30000, 30000, -30000, 25000, 60, 50, 0, 4, 9));
      send_frame(frame(32767, 32767, -32768, -32768, 0, 60, 5, 0, 9, 9));
      send_frame(frame(10000, -10000, 10000, -10000, 50000, 60, 50, 1, 4, 9));
      send_frame(frame(1234, -4321, 2222, -3333, 20000, 60, 3, 1, 4, 1));

      foreach (phase_plan[p]) begin
         drain();
         load_settings(phase_plan[p]);
         send_bursts(BeatsPerPhase);
      end

      drain();
      repeat (mcpl_pkg::Latency + 8) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("motor_current_power_limiter_tb: clean");
      end else begin
         $display("motor_current_power_limiter_tb: errors");
      end
      $finish;
   end

endmodule
